### rtl/core/tfa_pkg.sv
// Shared types and constants of the texture frame animator.
package tfa_pkg;

  // Field widths
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned RATE_W  = 8;
  localparam int unsigned RND_W   = 10;
  localparam int unsigned REQ_W   = 2;

  // Advance is step times rate
  localparam int unsigned ADV_W = STEP_W + RATE_W;
  // Signed sum and difference of position and advance
  localparam int unsigned SUM_W = ADV_W + 1;
  // Dividend magnitude: position plus advance stays below 2^ADV_W
  localparam int unsigned DIV_W = ADV_W;
  // Divisor and remainder hold up to twice the count minus one
  localparam int unsigned REM_W = COUNT_W + 1;
  // Remainder unit: quotient bits resolved per pipeline stage
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEP;

  // Random draws above this value start a blink
  localparam logic [RND_W-1:0] BLINK_THRESHOLD = 10'h3EF;

  // Blink request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_RANDOM   = 2'd0,
    REQ_START    = 2'd1,
    REQ_SUPPRESS = 2'd2,
    REQ_HOLD     = 2'd3
  } req_e;

  // How the back end forms the position from the remainder
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_MOD_FWD,
    KIND_MOD_BWD,
    KIND_PING
  } kind_e;

  // One input item
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic [STEP_W-1:0]  step;
    logic [RATE_W-1:0]  rate;
    logic [RND_W-1:0]   rnd;
    logic               blink;
    logic               act;
    logic               rev;
    req_e               req;
  } item_t;

  // Context carried alongside the remainder unit
  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
    logic               act;
    logic               rev;
    logic               consumed;
  } ctx_t;

  // One result item
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             act;
    logic             rev;
    logic             consumed;
  } result_t;

endpackage

### rtl/core/tfa_front.sv
// Front end: advance multiply, position add/subtract and mode classification.
module tfa_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tfa_pkg::item_t             item_i,
  output logic                       valid_o,
  output logic [tfa_pkg::DIV_W-1:0]  num_o,
  output logic [tfa_pkg::REM_W-1:0]  den_o,
  output tfa_pkg::ctx_t              ctx_o
);
  import tfa_pkg::*;

  // Stage 1: advance = step * rate
  logic               v1_q;
  item_t              it1_q;
  logic [ADV_W-1:0]   adv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      adv1_q <= ADV_W'(item_i.step) * ADV_W'(item_i.rate);
    end
  end

  // Stage 2: forward sum, backward difference, twice count minus one
  logic               v2_q;
  item_t              it2_q;
  logic [SUM_W-1:0]   sum2_q;
  logic [SUM_W-1:0]   diff2_q;
  logic [SUM_W-1:0]   per2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it2_q   <= it1_q;
      sum2_q  <= SUM_W'(it1_q.position) + SUM_W'(adv1_q);
      diff2_q <= SUM_W'(it1_q.position) - SUM_W'(adv1_q);
      per2_q  <= SUM_W'({it1_q.count, 1'b0}) - SUM_W'(1);
    end
  end

  // Stage 3: pick the mode, the dividend and the divisor
  logic               c_zero;
  logic               sum_ge_c;
  logic               diff_neg;
  logic [SUM_W-1:0]   refl;
  logic [SUM_W-1:0]   pp_val;
  logic [SUM_W-1:0]   pp_mag;
  logic               blink_start;
  logic [DIV_W-1:0]   num_d;
  logic [REM_W-1:0]   den_d;
  ctx_t               ctx_d;

  assign c_zero   = (it2_q.count == '0);
  assign sum_ge_c = (sum2_q >= SUM_W'(it2_q.count));
  assign diff_neg = diff2_q[SUM_W-1];
  assign refl     = per2_q - sum2_q;
  assign pp_val   = it2_q.rev ? diff2_q : sum2_q;
  assign pp_mag   = pp_val[SUM_W-1] ? (SUM_W'(0) - pp_val) : pp_val;
  assign blink_start = ((it2_q.req == REQ_RANDOM) && (it2_q.rnd > BLINK_THRESHOLD)) ||
                       (it2_q.req == REQ_START) || (it2_q.req == REQ_HOLD);

  always_comb begin
    num_d          = '0;
    den_d          = REM_W'(it2_q.count);
    ctx_d.kind     = KIND_DIRECT;
    ctx_d.pos      = it2_q.position;
    ctx_d.count    = it2_q.count;
    ctx_d.act      = it2_q.act;
    ctx_d.rev      = it2_q.rev;
    ctx_d.consumed = it2_q.blink;
    if (it2_q.blink) begin
      if (!it2_q.act) begin
        // idle: wait for a start
        if (blink_start) begin
          ctx_d.act = 1'b1;
          ctx_d.rev = 1'b0;
        end
      end else if (!it2_q.rev) begin
        // playing forward
        if (!sum_ge_c) begin
          ctx_d.pos = sum2_q[POS_W-1:0];
        end else if (it2_q.req == REQ_HOLD) begin
          ctx_d.pos = it2_q.count - POS_W'(1);
        end else if (refl[SUM_W-1]) begin
          ctx_d.pos = '0;
          ctx_d.act = 1'b0;
          ctx_d.rev = 1'b0;
        end else begin
          ctx_d.pos = refl[POS_W-1:0];
          ctx_d.rev = 1'b1;
        end
      end else begin
        // playing backward
        if (diff_neg) begin
          ctx_d.pos = '0;
          ctx_d.act = 1'b0;
          ctx_d.rev = 1'b0;
        end else begin
          ctx_d.pos = diff2_q[POS_W-1:0];
        end
      end
    end else if (it2_q.act) begin
      // ping-pong
      if (c_zero) begin
        ctx_d.pos = '0;
      end else begin
        if (pp_val[SUM_W-1]) begin
          ctx_d.rev = 1'b0;
        end
        if (pp_mag < SUM_W'(it2_q.count)) begin
          ctx_d.pos = pp_mag[POS_W-1:0];
        end else begin
          ctx_d.kind = KIND_PING;
          num_d      = pp_mag[DIV_W-1:0];
          den_d      = per2_q[REM_W-1:0];
        end
      end
    end else if (!it2_q.rev) begin
      // loop forward
      if (c_zero) begin
        ctx_d.pos = '0;
      end else begin
        ctx_d.kind = KIND_MOD_FWD;
        num_d      = sum2_q[DIV_W-1:0];
      end
    end else begin
      // loop backward
      if (!diff_neg) begin
        ctx_d.pos = diff2_q[POS_W-1:0];
      end else if (c_zero) begin
        ctx_d.pos = '0;
      end else begin
        ctx_d.kind = KIND_MOD_BWD;
        num_d      = DIV_W'(SUM_W'(0) - diff2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      den_o <= den_d;
      ctx_o <= ctx_d;
    end
  end

  // A divide is only issued for a nonzero count
  a_div_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (ctx_o.kind != KIND_DIRECT) |-> (ctx_o.count != '0))
    else $error("remainder issued with zero frame count");

  // Ping-pong reaches the divider only when out of range
  a_ping_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (ctx_o.kind == KIND_PING) |-> (num_o >= DIV_W'(ctx_o.count)))
    else $error("in-range ping-pong position sent to divider");

endmodule

### rtl/core/tfa_div.sv
// Pipelined restoring remainder unit with context carried per stage.
module tfa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tfa_pkg::DIV_W-1:0]  num_i,
  input  logic [tfa_pkg::REM_W-1:0]  den_i,
  input  tfa_pkg::ctx_t              ctx_i,
  output logic                       valid_o,
  output logic [tfa_pkg::REM_W-1:0]  rem_o,
  output tfa_pkg::ctx_t              ctx_o
);
  import tfa_pkg::*;

  logic             valid_q [DIV_STAGES];
  logic [REM_W-1:0] rem_q   [DIV_STAGES];
  logic [DIV_W-1:0] num_q   [DIV_STAGES];
  logic [REM_W-1:0] den_q   [DIV_STAGES];
  ctx_t             ctx_q   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic             valid_in;
    logic [REM_W-1:0] rem_in;
    logic [DIV_W-1:0] num_in;
    logic [REM_W-1:0] den_in;
    ctx_t             ctx_in;
    logic [REM_W-1:0] rem_d;
    logic [DIV_W-1:0] num_d;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign num_in   = num_i;
      assign den_in   = den_i;
      assign ctx_in   = ctx_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign num_in   = num_q[g-1];
      assign den_in   = den_q[g-1];
      assign ctx_in   = ctx_q[g-1];
    end

    // Shift in dividend bits, subtract the divisor where it fits
    always_comb begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] r;
      logic [DIV_W-1:0] n;
      r = rem_in;
      n = num_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {r, n[DIV_W-1]} - {1'b0, den_in};
        if (!trial[REM_W]) begin
          r = trial[REM_W-1:0];
        end else begin
          r = {r[REM_W-2:0], n[DIV_W-1]};
        end
        n = {n[DIV_W-2:0], 1'b0};
      end
      rem_d = r;
      num_d = n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        num_q[g] <= num_d;
        den_q[g] <= den_in;
        ctx_q[g] <= ctx_in;
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign rem_o   = rem_q[DIV_STAGES-1];
  assign ctx_o   = ctx_q[DIV_STAGES-1];

  // A finished remainder is below its divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[DIV_STAGES-1] && (ctx_q[DIV_STAGES-1].kind != KIND_DIRECT) |->
      (rem_q[DIV_STAGES-1] < den_q[DIV_STAGES-1]))
    else $error("remainder not below divisor");

endmodule

### rtl/core/tfa_back.sv
// Back end: form the new position and direction, hold the output register.
module tfa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tfa_pkg::REM_W-1:0]  rem_i,
  input  tfa_pkg::ctx_t              ctx_i,
  output logic                       valid_o,
  output tfa_pkg::result_t           res_o
);
  import tfa_pkg::*;

  logic [REM_W-1:0] period;
  result_t          res_d;

  assign period = REM_W'({ctx_i.count, 1'b0}) - REM_W'(1);

  // Map the remainder back onto a position
  always_comb begin
    res_d.pos      = ctx_i.pos;
    res_d.act      = ctx_i.act;
    res_d.rev      = ctx_i.rev;
    res_d.consumed = ctx_i.consumed;
    case (ctx_i.kind)
      KIND_DIRECT: begin
        res_d.pos = ctx_i.pos;
      end
      KIND_MOD_FWD: begin
        res_d.pos = rem_i[POS_W-1:0];
      end
      KIND_MOD_BWD: begin
        if (rem_i == '0) begin
          res_d.pos = '0;
        end else begin
          res_d.pos = ctx_i.count - rem_i[POS_W-1:0];
        end
      end
      KIND_PING: begin
        if (rem_i == '0) begin
          res_d.pos = '0;
          res_d.rev = 1'b1;
        end else if (rem_i < REM_W'(ctx_i.count)) begin
          res_d.pos = rem_i[POS_W-1:0];
          res_d.rev = 1'b0;
        end else begin
          res_d.pos = POS_W'(period - rem_i);
          res_d.rev = 1'b1;
        end
      end
      default: begin
        res_d.pos = ctx_i.pos;
      end
    endcase
    // Zero count always gives position zero
    if (ctx_i.count == '0) begin
      res_d.pos = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

  // Remainder-based positions land inside the animation
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (ctx_i.kind != KIND_DIRECT) && (ctx_i.count != '0) |->
      (res_d.pos < ctx_i.count))
    else $error("position beyond frame count");

endmodule

### rtl/core/texture_frame_animator.sv
// Top level of the texture frame animator: stream ports and pipeline wiring.
//
// One animation step per object. Each input transfer on the s_axis channel
// carries position, frame count, step, rate and random draw in tdata and the
// mode flags and blink request in tuser; each output transfer on m_axis
// carries the new position in tdata and the active, reverse and
// request-consumed bits in tuser. Every input gives exactly one result, in
// order.
// From input transfer to output valid, an item passes the step-times-rate
// multiply register, the add/subtract register, the mode selection
// register, the stages of the pipelined remainder unit (two quotient bits
// per stage over a 24-bit dividend) and the output register.
// Throughput is one item per cycle while the output is taken.
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops until the result is taken; nothing is lost or
// repeated.
module texture_frame_animator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position_in[15:0], frame_count[31:16], frame_step[47:32],
  // update_rate[55:48], random_value[65:56], zero[71:66]
  input  logic [71:0] s_axis_tdata,
  // blink_mode[0], active_in[1], reverse_in[2], blink_request[4:3]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position_out[15:0]
  output logic [15:0] m_axis_tdata,
  // active_out[0], reverse_out[1], request_consumed[2]
  output logic [2:0]  m_axis_tuser
);
  import tfa_pkg::*;

  logic             en;
  item_t            item;
  logic             fe_valid;
  logic [DIV_W-1:0] fe_num;
  logic [REM_W-1:0] fe_den;
  ctx_t             fe_ctx;
  logic             dv_valid;
  logic [REM_W-1:0] dv_rem;
  ctx_t             dv_ctx;
  result_t          res;

  // Advance everything unless a result waits untaken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack the input transfer
  assign item.position = s_axis_tdata[15:0];
  assign item.count    = s_axis_tdata[31:16];
  assign item.step     = s_axis_tdata[47:32];
  assign item.rate     = s_axis_tdata[55:48];
  assign item.rnd      = s_axis_tdata[65:56];
  assign item.blink    = s_axis_tuser[0];
  assign item.act      = s_axis_tuser[1];
  assign item.rev      = s_axis_tuser[2];
  assign item.req      = req_e'(s_axis_tuser[4:3]);

  tfa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (item),
    .valid_o (fe_valid),
    .num_o   (fe_num),
    .den_o   (fe_den),
    .ctx_o   (fe_ctx)
  );

  tfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .num_i   (fe_num),
    .den_i   (fe_den),
    .ctx_i   (fe_ctx),
    .valid_o (dv_valid),
    .rem_o   (dv_rem),
    .ctx_o   (dv_ctx)
  );

  tfa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .rem_i   (dv_rem),
    .ctx_i   (dv_ctx),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  // Pack the output transfer
  assign m_axis_tdata = res.pos;
  assign m_axis_tuser = {res.consumed, res.rev, res.act};

endmodule
